// File: rtl/core/lpmr_pkg.sv
// Shared types, codes and constants of the length-prefixed message ring.
// No dependencies; imported by lpmr_gather and length_prefixed_message_ring.
package lpmr_pkg;

    localparam int BUF_BYTES_DEF = 1024;
    localparam int MAX_MSG_DEF   = 64;

    // Gathered length holds up to MAX_MSG + 1 (saturated) with MAX_MSG at most 64.
    localparam int LEN_W = 7;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_DROP = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MSG    = 3'd1,
        ST_TOO_SMALL = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESULT,
        S_PUT_HDR0,
        S_PUT_HDR1,
        S_PUT_COPY,
        S_GET_H0,
        S_GET_H1,
        S_GET_CHK,
        S_GET_EMIT,
        S_DROP_CHK,
        S_DROP_H0,
        S_DROP_H1
    } t_state;

    // Length the current put byte closes with, and whether it exceeds MAX_MSG.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             too_long;
    } t_put_len;

    // Index width of a store of the given depth, at least one bit.
    function automatic int f_idx_w(input int depth);
        f_idx_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// File: rtl/core/lpmr_gather.sv
// Put-side gather stage: pending byte count and the assembly memory.
// Depends on lpmr_pkg; instantiated by length_prefixed_message_ring.
module lpmr_gather #(
    parameter int MAX_MSG = lpmr_pkg::MAX_MSG_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_put,
    input  logic [7:0]                            i_byte,
    input  logic                                  i_last,
    input  logic                                  i_rd_en,
    input  logic [lpmr_pkg::f_idx_w(MAX_MSG)-1:0] i_rd_addr,
    output logic [7:0]                            o_rd_data,
    output lpmr_pkg::t_put_len                    o_len
);
    import lpmr_pkg::*;

    localparam int AW  = f_idx_w(MAX_MSG);
    localparam int PCW = $clog2(MAX_MSG + 2);

    logic [7:0]     r_asm [MAX_MSG];
    logic [7:0]     r_rd_data;
    logic [PCW-1:0] r_pending;
    logic [PCW-1:0] n_pending;
    logic [PCW-1:0] w_len;
    logic           w_store;

    // Saturate at MAX_MSG + 1 so an overlong message stays flagged.
    assign w_len   = (r_pending <= PCW'(MAX_MSG)) ? r_pending + 1'b1 : r_pending;
    assign w_store = i_put && (r_pending < PCW'(MAX_MSG));

    always_comb begin
        n_pending = r_pending;
        if (i_put) begin
            n_pending = i_last ? '0 : w_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_asm[r_pending[AW-1:0]] <= i_byte;
        end
        if (i_rd_en) begin
            r_rd_data <= r_asm[i_rd_addr];
        end
    end

    assign o_rd_data      = r_rd_data;
    assign o_len.len      = LEN_W'(w_len);
    assign o_len.too_long = (w_len > PCW'(MAX_MSG));

endmodule

// File: rtl/core/length_prefixed_message_ring.sv
// Length-prefixed message ring: put bytes 1 per cycle unless stalled; a closing put commits.
// Get: check the header, then 1 byte per cycle unless the output stalls (ring read port bound).
// Drop: walk each stored message header from the read pointer, then give the result.
// Status-only results go out from S_RESULT; output register waits on i_out_stall.
// Reset (synchronous, active low) clears pointers, pending count and output valid; the ring
// and assembly memories are not cleared and hold anything until written.
module length_prefixed_message_ring #(
    parameter int BUF_BYTES = lpmr_pkg::BUF_BYTES_DEF,
    parameter int MAX_MSG   = lpmr_pkg::MAX_MSG_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_out_capacity,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_byte,
    output logic        o_byte_valid,
    output logic [2:0]  o_status,
    output logic        o_end_of_run
);
    import lpmr_pkg::*;

    localparam int PW = $clog2(BUF_BYTES);
    localparam int SW = ((PW > 16) ? PW : 16) + 2;
    localparam int CW = $clog2(MAX_MSG + 1);
    localparam int AW = f_idx_w(MAX_MSG);

    // Step a ring pointer by one with wrap.
    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(BUF_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    // Skip a header and its message. Stored lengths stay below BUF_BYTES - 2,
    // so one subtract brings the sum back into the ring.
    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p, input logic [15:0] len);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(len) + SW'(2);
        if (s >= SW'(BUF_BYTES)) begin
            s = s - SW'(BUF_BYTES);
        end
        f_adv = s[PW-1:0];
    endfunction

    // control state
    t_state        r_state, n_state;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic          r_out_valid;

    // working registers of the sequencer
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_cursor, n_cursor;
    logic [PW-1:0] r_head, n_head;
    logic [7:0]    r_lo, n_lo;
    logic [15:0]   r_len, n_len;
    logic [15:0]   r_cap, n_cap;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    t_status       r_status, n_status;

    // output register payload
    logic [7:0]    r_out_byte;
    logic          r_out_bvalid;
    t_status       r_out_status;
    logic          r_out_eor;

    // ring memory
    logic [7:0]    r_ring [BUF_BYTES];
    logic [7:0]    r_ring_rdata;
    logic          w_ring_we;
    logic [PW-1:0] w_ring_waddr;
    logic [7:0]    w_ring_wdata;
    logic          w_ring_re;
    logic [PW-1:0] w_ring_raddr;

    // gather stage
    logic          w_put;
    logic          w_asm_re;
    logic [AW-1:0] w_asm_raddr;
    logic [7:0]    w_asm_rdata;
    t_put_len      w_put_len;

    // combinational helpers
    logic          w_in_acc;
    logic          w_out_free;
    logic          w_empty;
    logic [SW-1:0] w_used;
    logic          w_no_space;
    logic [CW:0]   w_cnt_inc;
    logic [15:0]   w_cur_len;

    logic          w_out_load;
    logic [7:0]    w_load_byte;
    logic          w_load_bvalid;
    t_status       w_load_status;
    logic          w_load_eor;

    // Take requests only while the sequencer rests; puts that close no message
    // need no output slot, so they stream one per cycle.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_empty    = (r_rp == r_wp);
    assign w_put      = w_in_acc && (i_opcode == OP_PUT);

    // Bytes in use, then the commit test: length must stay below
    // BUF_BYTES - used - 2.
    assign w_used     = (r_wp >= r_rp) ? SW'(r_wp) - SW'(r_rp)
                                       : SW'(r_wp) + SW'(BUF_BYTES) - SW'(r_rp);
    assign w_no_space = (SW'(w_put_len.len) + w_used + SW'(2)) >= SW'(BUF_BYTES);

    assign w_cnt_inc  = {1'b0, r_cnt} + (CW + 1)'(1);
    assign w_cur_len  = {r_ring_rdata, r_lo};

    lpmr_gather #(
        .MAX_MSG (MAX_MSG)
    ) u_gather (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_put     (w_put),
        .i_byte    (i_data_byte),
        .i_last    (i_last_byte),
        .i_rd_en   (w_asm_re),
        .i_rd_addr (w_asm_raddr),
        .o_rd_data (w_asm_rdata),
        .o_len     (w_put_len)
    );

    always_comb begin
        n_state       = r_state;
        n_rp          = r_rp;
        n_wp          = r_wp;
        n_ptr         = r_ptr;
        n_cursor      = r_cursor;
        n_head        = r_head;
        n_lo          = r_lo;
        n_len         = r_len;
        n_cap         = r_cap;
        n_cnt         = r_cnt;
        n_n           = r_n;
        n_status      = r_status;
        w_ring_we     = 1'b0;
        w_ring_waddr  = r_ptr;
        w_ring_wdata  = w_asm_rdata;
        w_ring_re     = 1'b0;
        w_ring_raddr  = r_ptr;
        w_asm_re      = 1'b0;
        w_asm_raddr   = '0;
        w_out_load    = 1'b0;
        w_load_byte   = '0;
        w_load_bvalid = 1'b0;
        w_load_status = r_status;
        w_load_eor    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority if (i_opcode == OP_PUT) begin
                        // Close the message on its last byte; gathering is in u_gather.
                        if (i_last_byte) begin
                            priority if (w_put_len.too_long) begin
                                n_status = ST_TOO_LONG;
                                n_state  = S_RESULT;
                            end else if (w_no_space) begin
                                n_status = ST_NO_SPACE;
                                n_state  = S_RESULT;
                            end else begin
                                n_len   = 16'(w_put_len.len);
                                n_ptr   = r_wp;
                                n_state = S_PUT_HDR0;
                            end
                        end
                    end else if (i_opcode == OP_GET) begin
                        if (w_empty) begin
                            n_status = ST_NO_MSG;
                            n_state  = S_RESULT;
                        end else begin
                            w_ring_re    = 1'b1;
                            w_ring_raddr = r_rp;
                            n_ptr        = f_inc(r_rp);
                            n_cap        = i_out_capacity;
                            n_state      = S_GET_H0;
                        end
                    end else if (i_opcode == OP_DROP) begin
                        if (w_empty) begin
                            n_status = ST_NO_MSG;
                            n_state  = S_RESULT;
                        end else begin
                            n_cursor = r_rp;
                            n_head   = r_rp;
                            n_state  = S_DROP_CHK;
                        end
                    end else begin
                        // unused opcode: drop silently
                        n_state = S_IDLE;
                    end
                end
            end

            S_RESULT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            // Write the low length byte and fetch the first gathered byte.
            S_PUT_HDR0: begin
                w_ring_we    = 1'b1;
                w_ring_wdata = r_len[7:0];
                w_asm_re     = 1'b1;
                w_asm_raddr  = '0;
                n_cnt        = '0;
                n_ptr        = f_inc(r_ptr);
                n_state      = S_PUT_HDR1;
            end

            S_PUT_HDR1: begin
                w_ring_we    = 1'b1;
                w_ring_wdata = r_len[15:8];
                n_ptr        = f_inc(r_ptr);
                n_state      = S_PUT_COPY;
            end

            // Copy one byte per cycle; advance the write pointer on the last.
            S_PUT_COPY: begin
                w_ring_we = 1'b1;
                if (16'(w_cnt_inc) < r_len) begin
                    w_asm_re    = 1'b1;
                    w_asm_raddr = AW'(w_cnt_inc);
                    n_cnt       = CW'(w_cnt_inc);
                    n_ptr       = f_inc(r_ptr);
                end else begin
                    n_wp     = f_inc(r_ptr);
                    n_status = ST_OK;
                    n_state  = S_RESULT;
                end
            end

            S_GET_H0: begin
                n_lo         = r_ring_rdata;
                w_ring_re    = 1'b1;
                w_ring_raddr = r_ptr;
                n_ptr        = f_inc(r_ptr);
                n_state      = S_GET_H1;
            end

            S_GET_H1: begin
                n_len   = w_cur_len;
                n_state = S_GET_CHK;
            end

            // Refuse when the reader is too small; otherwise free the message
            // now and start streaming its bytes.
            S_GET_CHK: begin
                if (r_cap < r_len) begin
                    n_status = ST_TOO_SMALL;
                    n_state  = S_RESULT;
                end else begin
                    n_rp  = f_adv(r_rp, r_len);
                    n_n   = (r_len > 16'(MAX_MSG)) ? CW'(MAX_MSG) : CW'(r_len);
                    n_cnt = '0;
                    if (r_len == 16'd0) begin
                        n_status = ST_OK;
                        n_state  = S_RESULT;
                    end else begin
                        w_ring_re    = 1'b1;
                        w_ring_raddr = r_ptr;
                        n_state      = S_GET_EMIT;
                    end
                end
            end

            // Hold the fetched byte until the output slot frees, then fetch the next.
            S_GET_EMIT: begin
                if (w_out_free) begin
                    w_out_load    = 1'b1;
                    w_load_byte   = r_ring_rdata;
                    w_load_bvalid = 1'b1;
                    w_load_status = ST_OK;
                    w_load_eor    = (w_cnt_inc == {1'b0, r_n});
                    if (w_cnt_inc == {1'b0, r_n}) begin
                        n_state = S_IDLE;
                    end else begin
                        w_ring_re    = 1'b1;
                        w_ring_raddr = f_inc(r_ptr);
                        n_ptr        = f_inc(r_ptr);
                        n_cnt        = CW'(w_cnt_inc);
                    end
                end
            end

            // Walk headers until the cursor meets the write pointer; the last
            // header seen heads the newest message.
            S_DROP_CHK: begin
                if (r_cursor == r_wp) begin
                    n_wp     = r_head;
                    n_status = ST_OK;
                    n_state  = S_RESULT;
                end else begin
                    n_head       = r_cursor;
                    w_ring_re    = 1'b1;
                    w_ring_raddr = r_cursor;
                    n_ptr        = f_inc(r_cursor);
                    n_state      = S_DROP_H0;
                end
            end

            S_DROP_H0: begin
                n_lo         = r_ring_rdata;
                w_ring_re    = 1'b1;
                w_ring_raddr = r_ptr;
                n_state      = S_DROP_H1;
            end

            S_DROP_H1: begin
                n_cursor = f_adv(r_cursor, w_cur_len);
                n_state  = S_DROP_CHK;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_cursor <= n_cursor;
        r_head   <= n_head;
        r_lo     <= n_lo;
        r_len    <= n_len;
        r_cap    <= n_cap;
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_status <= n_status;
        if (w_out_load) begin
            r_out_byte   <= w_load_byte;
            r_out_bvalid <= w_load_bvalid;
            r_out_status <= w_load_status;
            r_out_eor    <= w_load_eor;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[w_ring_waddr] <= w_ring_wdata;
        end
        if (w_ring_re) begin
            r_ring_rdata <= r_ring[w_ring_raddr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_byte  = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_status     = r_out_status;
    assign o_end_of_run = r_out_eor;

endmodule
